FILE: hdl/rpsi_pkg.sv
// Shared types, constants, fixed-point helpers and the microprogram of the rate PID core.
package rpsi_pkg;

  // Number of axes and the width of an index into the per-axis state.
  localparam int AXES = 3;
  localparam int AX_W = (AXES > 1) ? $clog2(AXES) : 1;

  // Packed register layout: three 16-bit fields per register.
  localparam int FIELDS  = 3;
  localparam int FIELD_W = 16;
  localparam int REG_W   = FIELDS * FIELD_W;

  // Datapath widths.
  localparam int A_W    = 48;           // multiplier operand A, signed
  localparam int B_W    = 17;           // multiplier operand B, signed
  localparam int PROD_W = A_W + B_W;    // product register
  localparam int ACC_W  = PROD_W + 1;   // accumulator and rounding width
  localparam int PSUM_W = 40;           // drive sum before compensation
  localparam int LIM_W  = FIELD_W + 4;  // Q4.12 limit moved to Q16.16

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_PROP  = 3'd0;
  localparam logic [2:0] REG_INTEG = 3'd1;
  localparam logic [2:0] REG_DERIV = 3'd2;
  localparam logic [2:0] REG_PWGT  = 3'd3;
  localparam logic [2:0] REG_ILIM  = 3'd4;
  localparam logic [2:0] REG_OLIM  = 3'd5;
  localparam logic [2:0] REG_FILT  = 3'd6;

  // Fixed constants: 0.98 and 1/6 in Q16, and one in Q15.
  localparam logic signed [B_W-1:0] LEAK_Q16  = 17'sd64225;
  localparam logic signed [B_W-1:0] SIXTH_Q16 = 17'sd10923;
  localparam logic signed [B_W-1:0] ONE_Q15_S = 17'sd32768;
  localparam logic [FIELD_W-1:0]    ONE_Q15   = 16'd32768;

  localparam logic signed [ACC_W-1:0] S32_MAX = ACC_W'(32'h7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] S32_MIN = ~S32_MAX;

  // Microprogram addresses.
  typedef enum logic [4:0] {
    S_LEAK0  = 5'd0,
    S_LEAK1  = 5'd1,
    S_HOLD   = 5'd2,
    S_SIMP1  = 5'd3,
    S_SIMP2  = 5'd4,
    S_SIMP3  = 5'd5,
    S_ICLAMP = 5'd6,
    S_P1     = 5'd7,
    S_P2     = 5'd8,
    S_P3     = 5'd9,
    S_P4     = 5'd10,
    S_D1     = 5'd11,
    S_D2     = 5'd12,
    S_D3     = 5'd13,
    S_D4     = 5'd14,
    S_D5     = 5'd15,
    S_D6     = 5'd16,
    S_D7     = 5'd17,
    S_D8     = 5'd18,
    S_D9     = 5'd19,
    S_VC0    = 5'd20,
    S_VC1    = 5'd21
  } step_t;

  typedef enum logic [3:0] {
    A_INTG, A_S, A_T, A_E, A_G, A_DG, A_Y1, A_Y2, A_PSUM
  } asel_t;

  typedef enum logic [3:0] {
    B_LEAK, B_SIXTH, B_KI, B_KP, B_B, B_NB, B_KD, B_NF, B_F, B_VC
  } bsel_t;

  typedef enum logic [2:0] {T_NONE, T_RND16, T_RND15, T_SAT12, T_PROD} top_t;
  typedef enum logic [1:0] {I_NONE, I_LEAK, I_CLAMP} iop_t;
  typedef enum logic [1:0] {INC_NONE, INC_ZERO, INC_RND24} incop_t;
  typedef enum logic [1:0] {PS_NONE, PS_LOAD, PS_ADD12, PS_ADDY} psop_t;
  typedef enum logic [1:0] {AC_NONE, AC_LOAD16, AC_ADD, AC_SUB} acop_t;
  typedef enum logic [1:0] {J_NONE, J_NO_LEAK, J_HELD, J_NO_D} jc_t;

  // One control word of the microprogram.
  typedef struct packed {
    asel_t  a_sel;
    bsel_t  b_sel;
    top_t   t_op;
    iop_t   i_op;
    incop_t inc_op;
    psop_t  ps_op;
    acop_t  ac_op;
    logic   held_wr;
    logic   err_wr;
    logic   gyro_wr;
    logic   filt_wr;
    logic   fin;
    jc_t    jc;
    step_t  jmp;
  } ctrl_t;

  localparam ctrl_t CTRL_NOP = '{
    a_sel: A_INTG, b_sel: B_LEAK, t_op: T_NONE, i_op: I_NONE, inc_op: INC_NONE,
    ps_op: PS_NONE, ac_op: AC_NONE, held_wr: 1'b0, err_wr: 1'b0, gyro_wr: 1'b0,
    filt_wr: 1'b0, fin: 1'b0, jc: J_NONE, jmp: S_LEAK0
  };

  // Round to nearest, ties toward plus infinity, then shift right by s.
  function automatic logic signed [ACC_W-1:0] rnd(input logic signed [ACC_W-1:0] v,
                                                  input int unsigned s);
    logic signed [ACC_W-1:0] half;
    logic signed [ACC_W-1:0] sum;
    half = $signed(ACC_W'(1) << (s - 1));
    sum  = v + half;
    return sum >>> s;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > S32_MAX) return 32'sh7FFF_FFFF;
    if (v < S32_MIN) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Clamp to the symmetric range of a nonnegative limit.
  function automatic logic signed [31:0] clamp(input logic signed [ACC_W-1:0] v,
                                               input logic [LIM_W-1:0] lim);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = $signed(ACC_W'(lim));
    lo = -hi;
    if (v < lo) return lo[31:0];
    if (v > hi) return hi[31:0];
    return v[31:0];
  endfunction

  // Field of one axis from a packed register; axes past the packed fields read zero.
  function automatic logic [FIELD_W-1:0] get_field(input logic [REG_W-1:0] r,
                                                   input logic [AX_W-1:0] ax);
    logic [FIELD_W-1:0] f;
    f = '0;
    for (int k = 0; k < FIELDS; k++) begin
      if (32'(ax) == k) f = r[FIELD_W*k +: FIELD_W];
    end
    return f;
  endfunction

  // Microprogram ROM. The multiplier result of a step is used in the next step.
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t c;
    c = CTRL_NOP;
    unique case (s)
      S_LEAK0: begin
        c.a_sel = A_INTG;  c.b_sel = B_LEAK;
        c.jc = J_NO_LEAK;  c.jmp = S_HOLD;
      end
      S_LEAK1: c.i_op = I_LEAK;
      S_HOLD: begin
        c.a_sel = A_S;     c.b_sel = B_SIXTH;
        c.held_wr = 1'b1;  c.inc_op = INC_ZERO;
        c.jc = J_HELD;     c.jmp = S_ICLAMP;
      end
      S_SIMP1: c.t_op = T_RND16;
      S_SIMP2: begin
        c.a_sel = A_T;     c.b_sel = B_KI;
      end
      S_SIMP3: begin
        c.inc_op = INC_RND24;
        c.err_wr = 1'b1;
      end
      S_ICLAMP: begin
        c.i_op = I_CLAMP;
        c.a_sel = A_E;     c.b_sel = B_B;
      end
      S_P1: begin
        c.a_sel = A_G;     c.b_sel = B_NB;
        c.t_op = T_RND15;
      end
      S_P2: begin
        c.a_sel = A_T;     c.b_sel = B_KP;
        c.t_op = T_RND15;
      end
      S_P3: begin
        c.a_sel = A_T;     c.b_sel = B_KP;
        c.ps_op = PS_LOAD;
      end
      S_P4: begin
        c.a_sel = A_DG;    c.b_sel = B_KD;
        c.ps_op = PS_ADD12;
        c.jc = J_NO_D;     c.jmp = S_VC0;
      end
      S_D1: begin
        c.t_op = T_SAT12;
        c.gyro_wr = 1'b1;
      end
      S_D2: begin
        c.a_sel = A_T;     c.b_sel = B_NF;
      end
      S_D3: begin
        c.a_sel = A_Y1;    c.b_sel = B_F;
        c.t_op = T_PROD;
      end
      S_D4: begin
        c.a_sel = A_T;     c.b_sel = B_NF;
        c.ac_op = AC_LOAD16;
      end
      S_D5: begin
        c.a_sel = A_Y2;    c.b_sel = B_F;
        c.ac_op = AC_ADD;
      end
      S_D6: c.t_op = T_PROD;
      S_D7: begin
        c.a_sel = A_T;     c.b_sel = B_F;
      end
      S_D8: c.ac_op = AC_SUB;
      S_D9: begin
        c.ps_op = PS_ADDY;
        c.filt_wr = 1'b1;
      end
      S_VC0: begin
        c.a_sel = A_PSUM;  c.b_sel = B_VC;
      end
      // The operands stay selected so the product holds while the output waits.
      S_VC1: begin
        c.a_sel = A_PSUM;  c.b_sel = B_VC;
        c.fin = 1'b1;
      end
      default: c = CTRL_NOP;
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/rate_pid_with_simpson_integral_core.sv
// Top level of the three-axis rate PID core: microcoded sequencer, shared multiplier, state.
//
//   channel  signals                                          beat taken when
//   in       in_valid in_stall axis rate_error gyro_rate      in_valid && !in_stall
//            integ_leak volt_comp
//   out      out_valid out_stall drive integ_held             out_valid && !out_stall
//   config   psel penable pwrite paddr pwdata prdata pready   psel && penable && pwrite
//
// An item runs a microprogram of 9 to 22 steps through one 48x17 multiplier, and a new
// beat is taken only once the last one's program has finished; an axis out of range runs only the last step.
// Skipping the leak, an anti-windup hold and a zero derivative gain each shorten the program.
// The output register lets a new beat in while a result waits; the program then
// waits at its last step until the output register is free.
// Synchronous reset clears the per-axis state, the configuration registers and the handshakes.
module rate_pid_with_simpson_integral_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          axis,
  input  logic signed [31:0]  rate_error,
  input  logic signed [31:0]  gyro_rate,
  input  logic                integ_leak,
  input  logic [14:0]         volt_comp,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  drive,
  output logic                integ_held,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [5:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);
  import rpsi_pkg::*;

  // Configuration registers.
  logic [REG_W-1:0]   prop_gains;
  logic [REG_W-1:0]   integ_gains;
  logic [REG_W-1:0]   deriv_gains;
  logic [REG_W-1:0]   p_weights;
  logic [REG_W-1:0]   integ_limits;
  logic [REG_W-1:0]   out_limits;
  logic [FIELD_W-1:0] filter_coeff;

  // Per-axis state.
  logic signed [31:0] integral    [AXES];
  logic signed [31:0] prev_error  [AXES];
  logic signed [31:0] prev_error2 [AXES];
  logic signed [31:0] prev_gyro   [AXES];
  logic signed [31:0] filt_out1   [AXES];
  logic signed [31:0] filt_out2   [AXES];
  logic signed [31:0] prev_drive  [AXES];

  // Sequencer.
  logic  busy, busy_next;
  step_t upc, upc_next;
  ctrl_t ctrl;
  logic  jtake;

  // Captured item.
  logic [AX_W-1:0]    cur_ax;
  logic               bad;
  logic signed [31:0] cur_err;
  logic signed [31:0] cur_gyro;
  logic               cur_leak;
  logic [14:0]        cur_vc;

  // Datapath registers.
  logic signed [31:0]       intg;
  logic signed [31:0]       inc;
  logic signed [PSUM_W-1:0] psum;
  logic signed [A_W-1:0]    tmp;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic                     held;

  logic                  accept, in_range, out_free, fin_go, cfg_wr;
  logic [AX_W-1:0]       ax_idx;
  logic [FIELD_W-1:0]    kp, ki, kd, bw, il16, ol16, fcl, nf;
  logic [LIM_W-1:0]      ilim, olim;
  logic signed [31:0]    olim_s;
  logic signed [34:0]    s_val;
  logic signed [32:0]    dg;
  logic signed [A_W-1:0] a_op;
  logic signed [B_W-1:0] b_op;
  logic signed [ACC_W-1:0] p_ext;
  logic signed [ACC_W-1:0] p_r12, p_r14, p_r15, p_r16, p_r24;
  logic signed [31:0]    filt_y, drv;
  logic                  held_comb;

  // ---------------------------------------------------------------- config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gains   <= '0;
      integ_gains  <= '0;
      deriv_gains  <= '0;
      p_weights    <= '0;
      integ_limits <= '0;
      out_limits   <= '0;
      filter_coeff <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[5:3])
        REG_PROP:  prop_gains   <= pwdata[REG_W-1:0];
        REG_INTEG: integ_gains  <= pwdata[REG_W-1:0];
        REG_DERIV: deriv_gains  <= pwdata[REG_W-1:0];
        REG_PWGT:  p_weights    <= pwdata[REG_W-1:0];
        REG_ILIM:  integ_limits <= pwdata[REG_W-1:0];
        REG_OLIM:  out_limits   <= pwdata[REG_W-1:0];
        REG_FILT:  filter_coeff <= pwdata[FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      REG_PROP:  prdata = 64'(prop_gains);
      REG_INTEG: prdata = 64'(integ_gains);
      REG_DERIV: prdata = 64'(deriv_gains);
      REG_PWGT:  prdata = 64'(p_weights);
      REG_ILIM:  prdata = 64'(integ_limits);
      REG_OLIM:  prdata = 64'(out_limits);
      REG_FILT:  prdata = 64'(filter_coeff);
      default:   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- handshakes
  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  assign in_range = 32'(axis) < 32'(AXES);
  assign ax_idx   = in_range ? AX_W'(axis) : '0;
  assign out_free = !out_valid || !out_stall;
  assign fin_go   = busy && ctrl.fin && out_free;

  // ---------------------------------------------------------------- sequencer
  assign ctrl = ucode(upc);

  always_comb begin
    case (ctrl.jc)
      J_NO_LEAK: jtake = !cur_leak;
      J_HELD:    jtake = held_comb;
      J_NO_D:    jtake = (kd == '0);
      default:   jtake = 1'b0;
    endcase
  end

  always_comb begin
    upc_next  = upc;
    busy_next = busy;
    if (!busy) begin
      if (in_valid) begin
        busy_next = 1'b1;
        upc_next  = in_range ? S_LEAK0 : S_VC1;
      end
    end else if (ctrl.fin) begin
      if (out_free) busy_next = 1'b0;
    end else if (jtake) begin
      upc_next = ctrl.jmp;
    end else begin
      upc_next = step_t'(upc + 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      upc       <= S_LEAK0;
      out_valid <= 1'b0;
    end else begin
      busy <= busy_next;
      upc  <= upc_next;
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- operands
  assign kp   = get_field(prop_gains, cur_ax);
  assign ki   = get_field(integ_gains, cur_ax);
  assign kd   = get_field(deriv_gains, cur_ax);
  assign bw   = get_field(p_weights, cur_ax);
  assign il16 = get_field(integ_limits, cur_ax);
  assign ol16 = get_field(out_limits, cur_ax);
  assign ilim = {il16, 4'd0};
  assign olim = {ol16, 4'd0};
  assign olim_s = $signed(32'(olim));

  // A coefficient above one acts as one.
  assign fcl = (filter_coeff > ONE_Q15) ? ONE_Q15 : filter_coeff;
  assign nf  = ONE_Q15 - fcl;

  assign s_val = 35'(prev_error2[cur_ax]) + (35'(prev_error[cur_ax]) <<< 2) + 35'(cur_err);
  assign dg    = 33'(prev_gyro[cur_ax]) - 33'(cur_gyro);

  // The integral holds when the last drive sat at the limit in the error's direction.
  assign held_comb = (prev_drive[cur_ax] == olim_s && cur_err > 32'sd0) ||
                     (prev_drive[cur_ax] == -olim_s && cur_err < 32'sd0);

  always_comb begin
    case (ctrl.a_sel)
      A_INTG:  a_op = A_W'(intg);
      A_S:     a_op = A_W'(s_val);
      A_T:     a_op = tmp;
      A_E:     a_op = A_W'(cur_err);
      A_G:     a_op = A_W'(cur_gyro);
      A_DG:    a_op = A_W'(dg);
      A_Y1:    a_op = A_W'(filt_out1[cur_ax]);
      A_Y2:    a_op = A_W'(filt_out2[cur_ax]);
      A_PSUM:  a_op = A_W'(psum);
      default: a_op = '0;
    endcase
  end

  always_comb begin
    case (ctrl.b_sel)
      B_LEAK:  b_op = LEAK_Q16;
      B_SIXTH: b_op = SIXTH_Q16;
      B_KI:    b_op = $signed({1'b0, ki});
      B_KP:    b_op = $signed({1'b0, kp});
      B_B:     b_op = $signed({1'b0, bw});
      B_NB:    b_op = ONE_Q15_S - $signed({1'b0, bw});
      B_KD:    b_op = $signed({1'b0, kd});
      B_NF:    b_op = $signed({1'b0, nf});
      B_F:     b_op = $signed({1'b0, fcl});
      B_VC:    b_op = $signed({2'b00, cur_vc});
      default: b_op = '0;
    endcase
  end

  assign p_ext  = ACC_W'(prod);
  assign p_r12  = rnd(p_ext, 12);
  assign p_r14  = rnd(p_ext, 14);
  assign p_r15  = rnd(p_ext, 15);
  assign p_r16  = rnd(p_ext, 16);
  assign p_r24  = rnd(p_ext, 24);
  assign filt_y = sat32(rnd(acc, 30));
  assign drv    = clamp(ACC_W'(sat32(p_r14)), olim);

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    prod <= a_op * b_op;
    if (accept) begin
      cur_ax   <= ax_idx;
      bad      <= !in_range;
      cur_err  <= rate_error;
      cur_gyro <= gyro_rate;
      cur_leak <= integ_leak;
      cur_vc   <= volt_comp;
      intg     <= integral[ax_idx];
    end else if (busy) begin
      case (ctrl.t_op)
        T_RND16: tmp <= A_W'(p_r16);
        T_RND15: tmp <= A_W'(p_r15);
        T_SAT12: tmp <= A_W'(sat32(p_r12));
        T_PROD:  tmp <= A_W'(prod);
        default: ;
      endcase
      case (ctrl.i_op)
        I_LEAK:  intg <= sat32(p_r16);
        I_CLAMP: intg <= clamp(ACC_W'(intg) + ACC_W'(inc), ilim);
        default: ;
      endcase
      case (ctrl.inc_op)
        INC_ZERO:  inc <= '0;
        INC_RND24: inc <= 32'(p_r24);
        default: ;
      endcase
      case (ctrl.ps_op)
        PS_LOAD:  psum <= PSUM_W'(p_r12) + PSUM_W'(intg);
        PS_ADD12: psum <= psum + PSUM_W'(p_r12);
        PS_ADDY:  psum <= psum + PSUM_W'(filt_y);
        default: ;
      endcase
      // The filter sum is kept exact with Q30 coefficients; the feedback term
      // 2f*y1 in Q30 is y1*f shifted by sixteen.
      case (ctrl.ac_op)
        AC_LOAD16: acc <= p_ext <<< 16;
        AC_ADD:    acc <= acc + p_ext;
        AC_SUB:    acc <= acc - p_ext;
        default: ;
      endcase
      if (ctrl.held_wr) held <= held_comb;
    end
  end

  // ---------------------------------------------------------------- state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        integral[i]    <= '0;
        prev_error[i]  <= '0;
        prev_error2[i] <= '0;
        prev_gyro[i]   <= '0;
        filt_out1[i]   <= '0;
        filt_out2[i]   <= '0;
        prev_drive[i]  <= '0;
      end
    end else if (busy) begin
      if (ctrl.err_wr) begin
        prev_error2[cur_ax] <= prev_error[cur_ax];
        prev_error[cur_ax]  <= cur_err;
      end
      if (ctrl.gyro_wr) prev_gyro[cur_ax] <= cur_gyro;
      if (ctrl.filt_wr) begin
        filt_out2[cur_ax] <= filt_out1[cur_ax];
        filt_out1[cur_ax] <= filt_y;
      end
      if (fin_go && !bad) begin
        integral[cur_ax]   <= intg;
        prev_drive[cur_ax] <= drv;
      end
    end
  end

  // ---------------------------------------------------------------- output beat
  always_ff @(posedge clk) begin
    if (fin_go) begin
      drive      <= bad ? 32'sd0 : drv;
      integ_held <= bad ? 1'b0 : held;
    end
  end

endmodule
